/* hw/rtl/mah_pkg.sv */
// ----------------------------------------------------------------------------
// mah_pkg
// Shared types and constants for the multilevel alarm with hysteresis.
// ----------------------------------------------------------------------------
package mah_pkg;

    localparam int TEMP_W     = 12;
    localparam int TIME_W     = 40;
    localparam int DELAY_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int MASK_W     = 3;
    localparam int MAX_LEVELS = 3;

    localparam logic [TIME_W-1:0]        VALID_TIME_MIN = 40'd1600000000;
    localparam logic signed [TEMP_W:0]   HYST_TENTHS    = 13'sd10;
    localparam logic [DELAY_W-1:0]       DELAY_RESET    = 24'd1800;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [TIME_W-1:0]        t_time;

    localparam t_temp TH_RESET [MAX_LEVELS] = '{12'sd300, 12'sd350, 12'sd400};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL0_TH   = 2'd0,
        CFG_LEVEL1_TH   = 2'd1,
        CFG_LEVEL2_TH   = 2'd2,
        CFG_REARM_DELAY = 2'd3
    } t_cfg_idx;

    // one registered sample as seen by every level
    typedef struct packed {
        t_temp temp;
        t_time now;
        logic  clk_ok;
    } t_sample;

endpackage

/* hw/rtl/mah_level.sv */
// ----------------------------------------------------------------------------
// mah_level
// One alarm level: armed flag, last alarm stamp, re-arm and fire decision.
// ----------------------------------------------------------------------------
module mah_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  mah_pkg::t_sample                i_smp,
    input  mah_pkg::t_temp                  i_th,
    input  logic [mah_pkg::DELAY_W-1:0]     i_delay,
    output logic                            o_fire,
    output logic                            o_armed
);
    import mah_pkg::*;

    logic              r_armed;
    t_time             r_stamp;
    logic              n_armed;
    t_time             n_stamp;
    logic              take;
    t_time             stamp_eff;
    t_time             elapsed;
    logic              rearm;
    logic              armed_eff;
    logic signed [TEMP_W:0] temp_up;

    always_comb begin
        take      = !r_armed && i_smp.clk_ok && (r_stamp < VALID_TIME_MIN);
        stamp_eff = take ? i_smp.now : r_stamp;
        elapsed   = i_smp.now - stamp_eff;
        temp_up   = $signed({i_smp.temp[TEMP_W-1], i_smp.temp}) + HYST_TENTHS;
        rearm     = !r_armed && i_smp.clk_ok && (stamp_eff >= VALID_TIME_MIN)
                    && (i_smp.now >= stamp_eff)
                    && (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, i_delay})
                    && (temp_up <= $signed({i_th[TEMP_W-1], i_th}));
        armed_eff = r_armed || rearm;
        o_fire    = armed_eff && (i_smp.temp >= i_th);
        n_armed   = o_fire ? 1'b0 : armed_eff;
        n_stamp   = o_fire ? (i_smp.clk_ok ? i_smp.now : '0) : stamp_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b1;
            r_stamp <= '0;
        end else if (i_adv) begin
            r_armed <= n_armed;
            r_stamp <= n_stamp;
        end
    end

    assign o_armed = r_armed;

endmodule

/* hw/rtl/multilevel_alarm_hysteresis_rearm.sv */
// ----------------------------------------------------------------------------
// multilevel_alarm_hysteresis_rearm
// Temperature alarm with up to three levels, hysteresis and re-arm hold-off.
// ----------------------------------------------------------------------------
// Takes one sample word per clock and returns one result word per sample:
// the sample is registered, all levels evaluate in parallel (each a 40-bit
// elapsed-time subtract and compare against the re-arm delay) and the result
// is registered. Input and output registers decouple the two sides, so a full
// rate stream is sustained while the output side keeps tready high. Write
// configuration registers only while no sample is in flight.
module multilevel_alarm_hysteresis_rearm #(
    parameter int LEVEL_COUNT = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config port
    input  logic                               i_cfg_we,
    input  logic [mah_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mah_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [55:0]                        s_axis_tdata,  // temperature, current_time
    input  logic                               s_axis_tuser,  // audio_allowed
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // fired_mask, top_threshold
    output logic [1:0]                         m_axis_tuser   // alert_fired, play_audio
);
    import mah_pkg::*;

    t_temp                  r_th [LEVEL_COUNT];
    logic [DELAY_W-1:0]     r_delay;

    logic                   r_in_valid;
    t_sample                r_smp;
    logic                   r_audio;

    logic                   r_out_valid;
    logic [MASK_W-1:0]      r_mask;
    t_temp                  r_top;
    logic                   r_alert;
    logic                   r_play;

    logic                   adv;
    logic                   s_acc;
    logic [LEVEL_COUNT-1:0] w_fire;
    logic [LEVEL_COUNT-1:0] w_armed;
    logic [MASK_W-1:0]      n_mask;
    t_temp                  n_top;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVEL_COUNT; k++) r_th[k] <= TH_RESET[k];
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REARM_DELAY: r_delay <= i_cfg_wdata[DELAY_W-1:0];
                default: begin
                    for (int k = 0; k < LEVEL_COUNT; k++)
                        if (i_cfg_addr == CFG_IDX_W'(k))
                            r_th[k] <= i_cfg_wdata[TEMP_W-1:0];
                end
            endcase
        end
    end

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_smp.temp   <= s_axis_tdata[TEMP_W-1:0];
            r_smp.now    <= s_axis_tdata[TEMP_W +: TIME_W];
            r_smp.clk_ok <= s_axis_tdata[TEMP_W +: TIME_W] >= VALID_TIME_MIN;
            r_audio      <= s_axis_tuser;
        end
    end

    for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_level
        mah_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_smp   (r_smp),
            .i_th    (r_th[g]),
            .i_delay (r_delay),
            .o_fire  (w_fire[g]),
            .o_armed (w_armed[g])
        );
    end

    // highest fired level wins the threshold
    always_comb begin
        n_mask = '0;
        n_top  = '0;
        for (int k = 0; k < LEVEL_COUNT; k++) begin
            if (w_fire[k]) begin
                n_mask[k] = 1'b1;
                n_top     = r_th[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mask  <= n_mask;
            r_top   <= n_top;
            r_alert <= |n_mask;
            r_play  <= (|n_mask) && r_audio && r_smp.clk_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_top, r_mask};
    assign m_axis_tuser  = {r_play, r_alert};

    // ------------------------------------------------------------------------
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled with empty output register");

    a_alert_matches_mask: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[2:0] != 3'd0))
    ) else $error("alert flag disagrees with fired mask");

    a_quiet_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tdata[14:3] == 12'd0 && !m_axis_tuser[1])
    ) else $error("nonzero threshold or audio without an alarm");

    a_fire_disarms: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (adv && w_fire[0]) |=> !w_armed[0]
    ) else $error("level stayed armed after firing");

endmodule
